>>> rtl/sorted_key_list_table_macros.svh
// Assertion macros shared by the sorted key list table RTL.
`ifndef SORTED_KEY_LIST_TABLE_MACROS_SVH
`define SORTED_KEY_LIST_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SKL_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("sorted_key_list_table: assertion failed");
`define SKL_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("sorted_key_list_table: assertion failed");
`else
`define SKL_ASSERT(lbl, prop)
`define SKL_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

>>> rtl/skl_pkg.sv
// Package with sizes, request kinds and status codes of the sorted key list table.
`default_nettype none

package skl_pkg;

    localparam int CAPACITY  = 64;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int KEY_W     = 32;
    localparam int KIND_W    = 3;
    localparam int POS_W     = 7;
    localparam int STATUS_W  = 2;
    localparam int OUT_IDX_W = 6;
    localparam int OUT_CNT_W = 7;

    typedef logic signed [KEY_W-1:0] t_key;

    typedef enum logic [KIND_W-1:0] {
        KIND_SORTED_INS = 3'd0,
        KIND_POS_INS    = 3'd1,
        KIND_DELETE     = 3'd2,
        KIND_LIN_SEARCH = 3'd3,
        KIND_BIN_SEARCH = 3'd4
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BADPOS   = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

endpackage

`default_nettype wire

>>> rtl/skl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module skl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> rtl/sorted_key_list_table.sv
// Top level of the sorted key list table: request sequencer around one key memory.
//
// The table holds up to CAPACITY signed keys in one memory with a registered
// read, and works on one request at a time. Inserts and deletes move one entry
// per cycle through that memory, overlapping the read of the next entry with the
// write of the current one: a sorted insert shifts up each larger key and then
// places the new one, an insert at position p shifts up the entries from p on
// and places the key at p, a delete or linear search scans the entries in order
// (a delete keeps scanning to the end while it closes the gap), and a binary
// search issues a read and then compares for each probe. A full list, a bad
// position, an empty list for a scan and an unknown kind are answered without
// touching the memory. Every request moves its result into the output register
// once that register is free. A new request beat is taken while the previous
// result beat still waits in the output register. The memory needs no clearing after reset.
`default_nettype none
`include "sorted_key_list_table_macros.svh"

module sorted_key_list_table
    import skl_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [KIND_W-1:0]    i_kind,
    input  wire logic signed [KEY_W-1:0] i_key,
    input  wire logic [POS_W-1:0]     i_position,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [STATUS_W-1:0]       o_status,
    output logic [OUT_IDX_W-1:0]      o_found_index,
    output logic [OUT_CNT_W-1:0]      o_entry_count
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_SHIFT_UP = 8'b0000_0010,
        S_PLACE    = 8'b0000_0100,
        S_SCAN     = 8'b0000_1000,
        S_SHIFT_DN = 8'b0001_0000,
        S_BS_ISSUE = 8'b0010_0000,
        S_BS_CMP   = 8'b0100_0000,
        S_RESULT   = 8'b1000_0000
    } t_state;

    t_state               r_state, n_state;
    logic [KIND_W-1:0]    r_kind, n_kind;
    t_key                 r_key, n_key;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_ptr, n_ptr;
    logic [CNT_W-1:0]     r_lo, n_lo;
    logic [CNT_W-1:0]     r_hx, n_hx;
    logic [IDX_W-1:0]     r_mid, n_mid;
    logic [IDX_W-1:0]     r_widx, n_widx;
    t_status              r_status, n_status;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic                 r_out_valid, n_out_valid;
    t_status              r_out_status, n_out_status;
    logic [OUT_IDX_W-1:0] r_out_idx, n_out_idx;
    logic [OUT_CNT_W-1:0] r_out_cnt, n_out_cnt;

    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [KEY_W-1:0]     mem_wdata;
    logic [IDX_W-1:0]     mem_raddr;
    logic [KEY_W-1:0]     mem_rdata;
    t_key                 rd_key;
    logic [CNT_W:0]       bs_sum;
    logic [IDX_W-1:0]     bs_mid;
    logic [CNT_W-1:0]     ptr_inc;
    logic [CNT_W-1:0]     ptr_dec;
    logic                 move_up;

    skl_ram #(
        .WIDTH(KEY_W),
        .DEPTH(CAPACITY)
    ) u_key_store (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    assign rd_key  = t_key'(mem_rdata);
    assign bs_sum  = (CNT_W+1)'(r_lo) + (CNT_W+1)'(r_hx) - (CNT_W+1)'(1);
    assign bs_mid  = bs_sum[IDX_W:1];
    assign ptr_inc = r_ptr + CNT_W'(1);
    assign ptr_dec = r_ptr - CNT_W'(1);
    assign move_up = (r_kind == KIND_POS_INS) || (rd_key > r_key);

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_found_index = r_out_idx;
    assign o_entry_count = r_out_cnt;

    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_key        = r_key;
        n_count      = r_count;
        n_ptr        = r_ptr;
        n_lo         = r_lo;
        n_hx         = r_hx;
        n_mid        = r_mid;
        n_widx       = r_widx;
        n_status     = r_status;
        n_idx        = r_idx;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_idx    = r_out_idx;
        n_out_cnt    = r_out_cnt;
        mem_we       = 1'b0;
        mem_waddr    = r_ptr[IDX_W-1:0];
        mem_wdata    = r_key;
        mem_raddr    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_kind   = i_kind;
                    n_key    = i_key;
                    n_status = ST_OK;
                    n_idx    = '0;
                    n_state  = S_RESULT;
                    unique case (i_kind)
                        KIND_SORTED_INS: begin
                            if (r_count >= CNT_W'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else begin
                                n_ptr = r_count;
                                n_lo  = '0;
                                if (r_count == '0) begin
                                    n_state = S_PLACE;
                                end else begin
                                    mem_raddr = IDX_W'(r_count - CNT_W'(1));
                                    n_state   = S_SHIFT_UP;
                                end
                            end
                        end
                        KIND_POS_INS: begin
                            if (r_count >= CNT_W'(CAPACITY)) begin
                                n_status = ST_FULL;
                            end else if (32'(i_position) > 32'(r_count)) begin
                                n_status = ST_BADPOS;
                            end else begin
                                n_ptr = r_count;
                                n_lo  = CNT_W'(i_position);
                                if (r_count == CNT_W'(i_position)) begin
                                    n_state = S_PLACE;
                                end else begin
                                    mem_raddr = IDX_W'(r_count - CNT_W'(1));
                                    n_state   = S_SHIFT_UP;
                                end
                            end
                        end
                        KIND_DELETE, KIND_LIN_SEARCH: begin
                            if (r_count == '0) begin
                                n_status = ST_NOTFOUND;
                            end else begin
                                n_ptr     = '0;
                                mem_raddr = '0;
                                n_state   = S_SCAN;
                            end
                        end
                        KIND_BIN_SEARCH: begin
                            n_lo    = '0;
                            n_hx    = r_count;
                            n_state = S_BS_ISSUE;
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_SHIFT_UP: begin
                mem_we = 1'b1;
                if (move_up) begin
                    mem_wdata = mem_rdata;
                    n_ptr     = ptr_dec;
                    if (ptr_dec == r_lo) begin
                        n_state = S_PLACE;
                    end else begin
                        mem_raddr = IDX_W'(r_ptr - CNT_W'(2));
                    end
                end else begin
                    n_count = r_count + CNT_W'(1);
                    n_idx   = r_ptr[IDX_W-1:0];
                    n_state = S_RESULT;
                end
            end
            S_PLACE: begin
                mem_we  = 1'b1;
                n_count = r_count + CNT_W'(1);
                n_idx   = r_ptr[IDX_W-1:0];
                n_state = S_RESULT;
            end
            S_SCAN: begin
                if (rd_key == r_key) begin
                    n_idx = r_ptr[IDX_W-1:0];
                    if (r_kind == KIND_DELETE) begin
                        n_widx = r_ptr[IDX_W-1:0];
                        if (ptr_inc < r_count) begin
                            mem_raddr = ptr_inc[IDX_W-1:0];
                            n_ptr     = ptr_inc;
                            n_state   = S_SHIFT_DN;
                        end else begin
                            n_count = r_count - CNT_W'(1);
                            n_state = S_RESULT;
                        end
                    end else begin
                        n_state = S_RESULT;
                    end
                end else if (ptr_inc < r_count) begin
                    mem_raddr = ptr_inc[IDX_W-1:0];
                    n_ptr     = ptr_inc;
                end else begin
                    n_status = ST_NOTFOUND;
                    n_state  = S_RESULT;
                end
            end
            S_SHIFT_DN: begin
                mem_we    = 1'b1;
                mem_waddr = ptr_dec[IDX_W-1:0];
                mem_wdata = mem_rdata;
                if (ptr_inc < r_count) begin
                    mem_raddr = ptr_inc[IDX_W-1:0];
                    n_ptr     = ptr_inc;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    n_idx   = r_widx;
                    n_state = S_RESULT;
                end
            end
            S_BS_ISSUE: begin
                if (r_lo < r_hx) begin
                    mem_raddr = bs_mid;
                    n_mid     = bs_mid;
                    n_state   = S_BS_CMP;
                end else begin
                    n_status = ST_NOTFOUND;
                    n_state  = S_RESULT;
                end
            end
            S_BS_CMP: begin
                if (rd_key == r_key) begin
                    n_idx   = r_mid;
                    n_state = S_RESULT;
                end else begin
                    if (rd_key < r_key) begin
                        n_lo = CNT_W'(r_mid) + CNT_W'(1);
                    end else begin
                        n_hx = CNT_W'(r_mid);
                    end
                    n_state = S_BS_ISSUE;
                end
            end
            S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_idx    = (r_status == ST_OK) ? OUT_IDX_W'(r_idx) : '0;
                    n_out_cnt    = OUT_CNT_W'(r_count);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_key        <= n_key;
        r_ptr        <= n_ptr;
        r_lo         <= n_lo;
        r_hx         <= n_hx;
        r_mid        <= n_mid;
        r_widx       <= n_widx;
        r_status     <= n_status;
        r_idx        <= n_idx;
        r_out_status <= n_out_status;
        r_out_idx    <= n_out_idx;
        r_out_cnt    <= n_out_cnt;
    end

    `SKL_ASSERT(a_state_onehot, $onehot(r_state))
    `SKL_ASSERT(a_count_bound, r_count <= CNT_W'(CAPACITY))
    `SKL_ASSERT(a_write_in_move,
                !mem_we || r_state == S_SHIFT_UP || r_state == S_PLACE || r_state == S_SHIFT_DN)
    `SKL_ASSERT_NEXT(a_idle_keeps_count, r_state == S_IDLE, r_count == $past(r_count))

endmodule

`default_nettype wire

>>> sim/key_list_checker.sv
// Checker that tracks the key list contents and compares every reply beat with its prediction.
module key_list_checker
    import skl_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    input  wire logic                    i_in_ready,
    input  wire logic [KIND_W-1:0]       i_kind,
    input  wire logic signed [KEY_W-1:0] i_key,
    input  wire logic [POS_W-1:0]        i_position,
    input  wire logic                    i_out_valid,
    input  wire logic                    i_out_ready,
    input  wire logic [STATUS_W-1:0]     i_status,
    input  wire logic [OUT_IDX_W-1:0]    i_found_index,
    input  wire logic [OUT_CNT_W-1:0]    i_entry_count,
    output int                           o_pending,
    output int                           o_errors
);

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [OUT_IDX_W-1:0] index;
        logic [OUT_CNT_W-1:0] count;
    } t_reply;

    t_key   list_keys [CAPACITY];
    int     list_count;
    t_reply replies_due [$];
    t_reply reply_want;
    t_reply reply_got;
    t_reply reply_new;
    int     error_total;

    function automatic bit find_first(input t_key key, output int where);
        where = 0;
        for (int i = 0; i < list_count; i++) begin
            if (list_keys[i] == key) begin
                where = i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    task automatic place_key(input int slot, input t_key key);
        for (int i = list_count; i > slot; i--) begin
            list_keys[i] = list_keys[i-1];
        end
        list_keys[slot] = key;
        list_count++;
    endtask

    task automatic apply_request(
        input  logic [KIND_W-1:0] kind,
        input  t_key              key,
        input  logic [POS_W-1:0]  position,
        output t_reply            reply
    );
        t_status status;
        int      index;
        int      slot;
        int      lo;
        int      hi;
        int      mid;
        bit      found;
        status = ST_OK;
        index  = 0;
        case (kind)
            KIND_SORTED_INS: begin
                if (list_count >= CAPACITY) begin
                    status = ST_FULL;
                end else begin
                    slot = list_count;
                    while (slot > 0 && list_keys[slot-1] > key) slot--;
                    place_key(slot, key);
                    index = slot;
                end
            end
            KIND_POS_INS: begin
                if (list_count >= CAPACITY) begin
                    status = ST_FULL;
                end else if (int'(position) > list_count) begin
                    status = ST_BADPOS;
                end else begin
                    place_key(int'(position), key);
                    index = int'(position);
                end
            end
            KIND_DELETE: begin
                if (!find_first(key, slot)) begin
                    status = ST_NOTFOUND;
                end else begin
                    for (int i = slot; i + 1 < list_count; i++) begin
                        list_keys[i] = list_keys[i+1];
                    end
                    list_count--;
                    index = slot;
                end
            end
            KIND_LIN_SEARCH: begin
                if (find_first(key, slot)) begin
                    index = slot;
                end else begin
                    status = ST_NOTFOUND;
                end
            end
            KIND_BIN_SEARCH: begin
                lo    = 0;
                hi    = list_count - 1;
                found = 1'b0;
                while (!found && lo <= hi) begin
                    mid = (lo + hi) / 2;
                    if (list_keys[mid] == key) begin
                        found = 1'b1;
                        index = mid;
                    end else if (list_keys[mid] < key) begin
                        lo = mid + 1;
                    end else begin
                        hi = mid - 1;
                    end
                end
                if (!found) status = ST_NOTFOUND;
            end
            default: begin
            end
        endcase
        reply.status = status;
        reply.index  = index[OUT_IDX_W-1:0];
        reply.count  = list_count[OUT_CNT_W-1:0];
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            list_count  = 0;
            error_total = 0;
            replies_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                reply_got = '{i_status, i_found_index, i_entry_count};
                if (replies_due.size() == 0) begin
                    $display("%0t: unexpected reply beat, status %0d index %0d count %0d",
                             $time, i_status, i_found_index, i_entry_count);
                    error_total++;
                end else begin
                    reply_want = replies_due.pop_front();
                    if (reply_want != reply_got) begin
                        $display("%0t: expected status %0d index %0d count %0d, got %0d %0d %0d",
                                 $time, reply_want.status, reply_want.index, reply_want.count,
                                 reply_got.status, reply_got.index, reply_got.count);
                        error_total++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                apply_request(i_kind, i_key, i_position, reply_new);
                replies_due.push_back(reply_new);
            end
        end
        o_pending <= replies_due.size();
        o_errors  <= error_total;
    end

endmodule

>>> sim/tb.sv
// Testbench top for the sorted key list table: clock, reset, request stimulus and verdict.
module tb;
    import skl_pkg::*;

    localparam int   RANDOM_ITEMS = 550;
    localparam int   CYCLE_LIMIT  = 1000000;
    localparam int   DRAIN_CYCLES = 2 * CAPACITY + 10;
    localparam int   POOL_SIZE    = 12;
    localparam t_key KEY_MIN      = 32'sh8000_0000;
    localparam t_key KEY_MAX      = 32'sh7fff_ffff;

    logic                    clk;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    out_ready = 1'b0;
    logic [KIND_W-1:0]       kind      = '0;
    t_key                    key       = '0;
    logic [POS_W-1:0]        position  = '0;
    logic                    in_ready;
    logic                    out_valid;
    logic [STATUS_W-1:0]     status;
    logic [OUT_IDX_W-1:0]    found_index;
    logic [OUT_CNT_W-1:0]    entry_count;
    int                      pending;
    int                      mismatches;
    int                      sent          = 0;
    int                      send_idle_pct = 0;
    int                      stall_pct     = 0;
    int                      random_start;
    int                      phase;
    int                      roll;
    t_key                    key_pool [POOL_SIZE];

    sorted_key_list_table DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_kind        (kind),
        .i_key         (key),
        .i_position    (position),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_status      (status),
        .o_found_index (found_index),
        .o_entry_count (entry_count)
    );

    key_list_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_kind        (kind),
        .i_key         (key),
        .i_position    (position),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_status      (status),
        .i_found_index (found_index),
        .i_entry_count (entry_count),
        .o_pending     (pending),
        .o_errors      (mismatches)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Mismatches found");
        $finish;
    end

    always @(posedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic send_request(
        input logic [KIND_W-1:0] req_kind,
        input t_key              req_key,
        input logic [POS_W-1:0]  req_position
    );
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= req_kind;
        key      <= req_key;
        position <= req_position;
        do @(posedge clk); while (!in_ready);
        sent++;
    endtask

    function automatic t_key pick_key();
        if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return t_key'($urandom);
    endfunction

    function automatic t_kind pick_search();
        return ($urandom_range(0, 1) == 1) ? KIND_BIN_SEARCH : KIND_LIN_SEARCH;
    endfunction

    initial begin
        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = 0;
        key_pool[3] = -1;
        key_pool[4] = 1;
        for (int i = 5; i < POOL_SIZE; i++) begin
            key_pool[i] = t_key'($urandom_range(0, 40)) - 20;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        send_request(KIND_LIN_SEARCH, 7, 0);
        send_request(KIND_BIN_SEARCH, 7, 0);
        send_request(KIND_DELETE, 7, 0);
        send_request(KIND_POS_INS, 3, 1);
        send_request(KIND_POS_INS, KEY_MAX, 0);
        send_request(KIND_SORTED_INS, KEY_MIN, 0);
        send_request(KIND_SORTED_INS, 0, 0);
        send_request(KIND_SORTED_INS, 0, 0);
        send_request(KIND_POS_INS, -1, 4);
        send_request(KIND_POS_INS, 5, '1);
        send_request(KIND_POS_INS, 5, POS_W'(CAPACITY));
        send_request(KIND_LIN_SEARCH, 0, 0);
        send_request(KIND_BIN_SEARCH, -1, 0);
        send_request(KIND_BIN_SEARCH, KEY_MAX, 0);
        for (int k = KIND_BIN_SEARCH + 1; k < 2 ** KIND_W; k++) begin
            send_request(KIND_W'(k), t_key'($urandom), POS_W'($urandom_range(0, 127)));
        end
        send_request(KIND_DELETE, 0, 0);
        send_request(KIND_DELETE, 12345, 0);
        send_request(KIND_LIN_SEARCH, KEY_MAX, 0);
        send_request(KIND_BIN_SEARCH, KEY_MIN, 0);
        send_request(KIND_SORTED_INS, -1, 0);

        random_start = sent;
        while (sent < random_start + RANDOM_ITEMS) begin
            phase = (sent - random_start) * 4 / RANDOM_ITEMS;
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 50;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 50;
                end
                default: begin
                    send_idle_pct = 23;
                    stall_pct     = 23;
                end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < 40) begin
                repeat ($urandom_range(5, 70)) begin
                    send_request(KIND_SORTED_INS, pick_key(), POS_W'($urandom_range(0, 127)));
                    if ($urandom_range(0, 99) < 30) begin
                        send_request(pick_search(), pick_key(), POS_W'($urandom_range(0, 127)));
                    end
                end
            end else if (roll < 65) begin
                repeat ($urandom_range(5, 70)) begin
                    send_request(KIND_DELETE, pick_key(), POS_W'($urandom_range(0, 127)));
                    if ($urandom_range(0, 99) < 20) begin
                        send_request(pick_search(), pick_key(), POS_W'($urandom_range(0, 127)));
                    end
                end
            end else if (roll < 80) begin
                repeat ($urandom_range(3, 20)) begin
                    send_request(KIND_POS_INS, pick_key(),
                                 POS_W'(($urandom_range(0, 99) < 80) ? $urandom_range(0, 16)
                                                                     : $urandom_range(0, 127)));
                end
                repeat ($urandom_range(2, 6)) begin
                    send_request(KIND_BIN_SEARCH, pick_key(), POS_W'($urandom_range(0, 127)));
                end
            end else begin
                repeat ($urandom_range(3, 15)) begin
                    send_request(KIND_W'($urandom_range(0, 2 ** KIND_W - 1)),
                                 ($urandom_range(0, 1) == 1) ? t_key'($urandom) : pick_key(),
                                 POS_W'($urandom_range(0, 127)));
                end
            end
        end
        in_valid <= 1'b0;

        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
